/* rtl/core/sat_pkg.sv */
// Shared constants, types and helpers for the sorted address table.
// No dependencies; sat_dp, sat_ctrl and sorted_address_table_unit refer to it by scoped name.
package sat_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 48;
  localparam int HANDLE_W    = 16;
  localparam int PRIO_W      = 8;
  localparam int SPAN_W      = 9;
  localparam int OUT_W       = 9;
  localparam int ENTRY_W     = KEY_W + HANDLE_W + PRIO_W;

  typedef enum logic [1:0] {
    ACT_SEARCH = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_COUNT  = 2'd3
  } action_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture request, open the search range
    logic look;       // issue read at the midpoint
    logic cmp;        // narrow range or record the match
    logic miss;       // search closed without a match
    logic set_ok;
    logic mv_up;      // set up an upward shift from the insertion point
    logic mv_dn;      // set up a downward shift over the deleted entry
    logic scan_init;  // set up a priority scan over all entries
    logic mv_step;
    logic place;      // write the new entry and grow the table
    logic dec;        // shrink the table
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    action_t act;
    logic    open;       // search range not yet empty
    logic    eq;         // read key matches
    logic    hit;
    logic    full;
    logic    mv_active;  // reads left or a transfer in flight
  } status_t;

  // Fit a count-wide value into an output field, masking or zero-padding
  function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_W-1:0] t;
    t = {{OUT_W{1'b0}}, v};
    return t[OUT_W-1:0];
  endfunction

endpackage

/* rtl/core/sorted_address_table_unit.sv */
// Sorted address table: one request in, one result out, strobed by done.
// A search makes at most log2(entries)+1 probes. Add then shifts the entries from the insertion
// point up before writing the new entry, delete shifts the entries after the match down, and
// count scans every entry. The next request is taken in the cycle after the result.
// Results cannot be stalled. Synchronous reset empties the table; entry contents are kept.
// Depends on sat_pkg, sat_ctrl, sat_dp and sat_ram.
module sorted_address_table_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [31:0]                   addr,
  input  logic [15:0]                   port,
  input  logic [sat_pkg::HANDLE_W-1:0]  handle,
  input  logic [sat_pkg::PRIO_W-1:0]    prio,
  input  logic [sat_pkg::SPAN_W-1:0]    span,
  output logic                          done,
  output logic                          ok,
  output logic [sat_pkg::OUT_W-1:0]     position,
  output logic [sat_pkg::HANDLE_W-1:0]  found_handle,
  output logic [sat_pkg::PRIO_W-1:0]    found_prio,
  output logic [sat_pkg::OUT_W-1:0]     entries,
  output logic [sat_pkg::OUT_W-1:0]     members
);

  sat_pkg::cmd_t    cmd;
  sat_pkg::status_t st;

  sat_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .st   (st)
  );

  sat_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .action      (action),
    .addr        (addr),
    .port        (port),
    .handle      (handle),
    .prio        (prio),
    .span        (span),
    .ok          (ok),
    .position    (position),
    .found_handle(found_handle),
    .found_prio  (found_prio),
    .entries     (entries),
    .members     (members)
  );

endmodule

/* rtl/core/sat_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sat_dp.sv */
// Datapath of the sorted address table: request registers, search range,
// shift/scan engine and the entry RAM. Depends on sat_pkg and sat_ram.
module sat_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  sat_pkg::cmd_t                 cmd,
  output sat_pkg::status_t              st,
  input  logic [1:0]                    action,
  input  logic [31:0]                   addr,
  input  logic [15:0]                   port,
  input  logic [sat_pkg::HANDLE_W-1:0]  handle,
  input  logic [sat_pkg::PRIO_W-1:0]    prio,
  input  logic [sat_pkg::SPAN_W-1:0]    span,
  output logic                          ok,
  output logic [sat_pkg::OUT_W-1:0]     position,
  output logic [sat_pkg::HANDLE_W-1:0]  found_handle,
  output logic [sat_pkg::PRIO_W-1:0]    found_prio,
  output logic [sat_pkg::OUT_W-1:0]     entries,
  output logic [sat_pkg::OUT_W-1:0]     members
);

  localparam int IW = sat_pkg::IDX_W;
  localparam int CW = sat_pkg::CNT_W;
  localparam int KW = sat_pkg::KEY_W;
  localparam int HW = sat_pkg::HANDLE_W;
  localparam int PW = sat_pkg::PRIO_W;
  localparam int EW = sat_pkg::ENTRY_W;

  sat_pkg::action_t act;
  logic [KW-1:0]    key;
  logic [HW-1:0]    hnd;
  logic [PW-1:0]    lowp;
  logic [sat_pkg::SPAN_W-1:0] win;

  logic [CW-1:0] count;
  logic [CW-1:0] lo, hi, pos;
  logic [IW-1:0] mid;
  logic          hit;
  logic          ok_r;
  logic [HW-1:0] fh;
  logic [PW-1:0] fp;
  logic [CW-1:0] hits;

  // shift / scan engine
  logic [IW-1:0] src;
  logic [CW-1:0] left;
  logic          up;
  logic          scan;
  logic          pend;
  logic [IW-1:0] pend_dst;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [CW:0]   mid_sum;
  logic [KW-1:0] rkey;
  logic [PW-1:0] rprio;
  logic [9:0]    p10, lo10, lim10;
  logic          in_win;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign rkey    = rdata[EW-1 -: KW];
  assign rprio   = rdata[PW-1:0];
  assign p10     = {2'b00, rprio};
  assign lo10    = {2'b00, lowp};
  assign lim10   = lo10 + {1'b0, win};
  assign in_win  = (p10 >= lo10) && (p10 < lim10);

  always_comb begin
    raddr = src;
    if (cmd.look) begin
      raddr = mid_sum[IW:1];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pend_dst;
    wdata = rdata;
    if (cmd.place) begin
      we    = 1'b1;
      waddr = pos[IW-1:0];
      wdata = {key, hnd, lowp};
    end else if (cmd.mv_step && pend && !scan) begin
      we = 1'b1;
    end
  end

  sat_ram #(
    .WIDTH(EW),
    .DEPTH(sat_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // request capture, search and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= sat_pkg::action_t'(action);
      key  <= {addr, port};
      hnd  <= handle;
      lowp <= prio;
      win  <= span;
      lo   <= '0;
      hi   <= count;
      pos  <= '0;
      hit  <= 1'b0;
      ok_r <= 1'b0;
      fh   <= '0;
      fp   <= '0;
      hits <= '0;
    end
    if (cmd.look) begin
      mid <= mid_sum[IW:1];
    end
    if (cmd.cmp) begin
      if (rkey == key) begin
        hit <= 1'b1;
        pos <= CW'(mid);
        // report the stored entry on a search only
        if (act == sat_pkg::ACT_SEARCH) begin
          fh <= rdata[PW +: HW];
          fp <= rprio;
        end
      end else if (key > rkey) begin
        lo <= CW'(mid) + CW'(1);
      end else begin
        hi <= CW'(mid);
      end
    end
    if (cmd.miss) begin
      pos <= lo;
    end
    if (cmd.set_ok) begin
      ok_r <= 1'b1;
    end
    if (cmd.mv_step && pend && scan && in_win) begin
      hits <= hits + CW'(1);
    end
  end

  // table size
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.place) begin
      count <= count + CW'(1);
    end else if (cmd.dec) begin
      count <= count - CW'(1);
    end
  end

  // shift / scan engine: one read issued per cycle, data lands in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      pend <= 1'b0;
    end else if (cmd.mv_up) begin
      up   <= 1'b1;
      scan <= 1'b0;
      src  <= IW'(count - CW'(1));
      left <= count - pos;
      pend <= 1'b0;
    end else if (cmd.mv_dn) begin
      up   <= 1'b0;
      scan <= 1'b0;
      src  <= IW'(pos + CW'(1));
      left <= count - pos - CW'(1);
      pend <= 1'b0;
    end else if (cmd.scan_init) begin
      up   <= 1'b0;
      scan <= 1'b1;
      src  <= '0;
      left <= count;
      pend <= 1'b0;
    end else if (cmd.mv_step) begin
      if (left != '0) begin
        src      <= up ? src - IW'(1) : src + IW'(1);
        pend_dst <= up ? src + IW'(1) : src - IW'(1);
        left     <= left - CW'(1);
        pend     <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  assign st.act       = act;
  assign st.open      = (lo < hi);
  assign st.eq        = (rkey == key);
  assign st.hit       = hit;
  assign st.full      = (count == CW'(sat_pkg::TABLE_DEPTH));
  assign st.mv_active = (left != '0) || pend;

  assign ok           = ok_r;
  assign position     = sat_pkg::to_out(pos);
  assign found_handle = fh;
  assign found_prio   = fp;
  assign entries      = sat_pkg::to_out(count);
  assign members      = sat_pkg::to_out(hits);

endmodule

/* rtl/core/sat_ctrl.sv */
// Controller of the sorted address table: sequences search, shift, scan
// and result phases. Depends on sat_pkg.
module sat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output sat_pkg::cmd_t    cmd,
  input  sat_pkg::status_t st
);

  typedef enum logic [7:0] {
    IDLE   = 8'b0000_0001,
    LOOK   = 8'b0000_0010,
    CMP    = 8'b0000_0100,
    DECIDE = 8'b0000_1000,
    MOVE   = 8'b0001_0000,
    PLACE  = 8'b0010_0000,
    SCAN   = 8'b0100_0000,
    FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = LOOK;
        end
      end
      LOOK: begin
        if (st.act == sat_pkg::ACT_COUNT) begin
          cmd.scan_init = 1'b1;
          state_next    = SCAN;
        end else if (st.open) begin
          cmd.look   = 1'b1;
          state_next = CMP;
        end else begin
          cmd.miss   = 1'b1;
          state_next = DECIDE;
        end
      end
      CMP: begin
        cmd.cmp    = 1'b1;
        state_next = st.eq ? DECIDE : LOOK;
      end
      DECIDE: begin
        state_next = FINISH;
        case (st.act)
          sat_pkg::ACT_SEARCH: begin
            cmd.set_ok = st.hit;
          end
          sat_pkg::ACT_ADD: begin
            if (!st.hit && !st.full) begin
              cmd.mv_up  = 1'b1;
              state_next = MOVE;
            end
          end
          sat_pkg::ACT_DELETE: begin
            if (st.hit) begin
              cmd.mv_dn  = 1'b1;
              state_next = MOVE;
            end
          end
          default: begin
            state_next = FINISH;
          end
        endcase
      end
      MOVE: begin
        cmd.mv_step = 1'b1;
        if (!st.mv_active) begin
          if (st.act == sat_pkg::ACT_ADD) begin
            state_next = PLACE;
          end else begin
            cmd.dec    = 1'b1;
            cmd.set_ok = 1'b1;
            state_next = FINISH;
          end
        end
      end
      PLACE: begin
        cmd.place  = 1'b1;
        cmd.set_ok = 1'b1;
        state_next = FINISH;
      end
      SCAN: begin
        cmd.mv_step = 1'b1;
        if (!st.mv_active) begin
          cmd.set_ok = 1'b1;
          state_next = FINISH;
        end
      end
      FINISH: begin
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign busy = (state != IDLE);
  assign done = (state == FINISH);

endmodule
